// ----- design/slm_pkg.sv -----
package slm_pkg;

  // Default pool size of the step slots.
  localparam int unsigned POOL_SLOTS_DEF = 16;

  // Payload widths fixed by the request and result formats.
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CNT_O_W = 5;
  localparam int unsigned STAT_W  = 2;

  // Request codes; codes six and seven behave as a peek.
  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND    = 3'd0,
    REQ_COMPLETE  = 3'd1,
    REQ_DROP_PEND = 3'd2,
    REQ_DROP_DONE = 3'd3,
    REQ_REWIND    = 3'd4,
    REQ_PEEK      = 3'd5
  } req_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_BADCODE = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_LINK,
    S_UNLINK,
    S_HEAD,
    S_OUT
  } state_t;

endpackage

// ----- design/step_list_manager_with_rewind.sv -----
// Step list manager with rewind.
// A pool of POOL_SLOTS slots holds steps (opcode and tag) as one ordered
// list: completed steps, then pending steps. Requests enter on the in_
// stream (append, complete next, drop pending, drop last done, rewind,
// peek); each gives exactly one result on the out_ stream with a status,
// the head pending opcode and tag (zero when none) and both counts.
// Links, opcodes and tags live in three single-port-read memories; the
// free map is a flop vector with a lowest-free-slot encoder.
// A request passes the link step, the unlink step (drop last done only,
// which needs a second dependent link read), the head step and the
// output step; the link read, the write-back and the step data read are
// done in sequence, and no new request is taken until its result is loaded.
// in_tready is high only while the sequencer is idle. A finished result
// waits in the output register; the next request is still taken, and its
// own result waits until the receiver takes the pending one.
// Reset empties the list, frees all slots and drops any unsent result;
// no clearing pass is needed.
module step_list_manager_with_rewind #(
  parameter int unsigned POOL_SLOTS = slm_pkg::POOL_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] req_type, [34:3] step_code, [66:35] step_tag
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] status, [33:2] head_code, [65:34] head_tag,
  // [70:66] pending_count, [75:71] done_count
  output logic [79:0] out_tdata
);

  localparam int unsigned SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned WW = slm_pkg::WORD_W;

  logic [slm_pkg::STAT_W-1:0]  status;
  logic [WW-1:0]               head_code, head_tag;
  logic [slm_pkg::CNT_O_W-1:0] pending_count, done_count;

  logic          nl_wr_en, pl_wr_en, dm_wr_en, dm_rd_en;
  logic [SW-1:0] nl_wr_addr, nl_wr_data, nl_rd_addr, nl_rd_data;
  logic [SW-1:0] pl_wr_addr, pl_wr_data, pl_rd_addr, pl_rd_data;
  logic [SW-1:0] dm_wr_addr, dm_rd_addr;
  logic [2*WW-1:0] dm_wr_data, dm_rd_data;
  logic          alloc_en, release_en, free_found;
  logic [SW-1:0] release_slot, free_low;

  // Sequencer holding list pointers, counts and the result register.
  slm_seq #(.POOL_SLOTS(POOL_SLOTS)) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_req       (in_tdata[2:0]),
    .in_code      (in_tdata[34:3]),
    .in_tag       (in_tdata[66:35]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_status   (status),
    .out_code     (head_code),
    .out_tag      (head_tag),
    .out_pend     (pending_count),
    .out_done     (done_count),
    .nl_wr_en     (nl_wr_en),
    .nl_wr_addr   (nl_wr_addr),
    .nl_wr_data   (nl_wr_data),
    .nl_rd_addr   (nl_rd_addr),
    .nl_rd_data   (nl_rd_data),
    .pl_wr_en     (pl_wr_en),
    .pl_wr_addr   (pl_wr_addr),
    .pl_wr_data   (pl_wr_data),
    .pl_rd_addr   (pl_rd_addr),
    .pl_rd_data   (pl_rd_data),
    .dm_wr_en     (dm_wr_en),
    .dm_wr_addr   (dm_wr_addr),
    .dm_wr_data   (dm_wr_data),
    .dm_rd_en     (dm_rd_en),
    .dm_rd_addr   (dm_rd_addr),
    .dm_rd_data   (dm_rd_data),
    .alloc_en     (alloc_en),
    .release_en   (release_en),
    .release_slot (release_slot),
    .free_found   (free_found),
    .free_low     (free_low)
  );

  // Forward links.
  slm_ram #(.DEPTH(POOL_SLOTS), .WIDTH(SW)) u_next_ram (
    .clk     (clk),
    .wr_en   (nl_wr_en),
    .wr_addr (nl_wr_addr),
    .wr_data (nl_wr_data),
    .rd_en   (1'b1),
    .rd_addr (nl_rd_addr),
    .rd_data (nl_rd_data)
  );

  // Backward links.
  slm_ram #(.DEPTH(POOL_SLOTS), .WIDTH(SW)) u_prev_ram (
    .clk     (clk),
    .wr_en   (pl_wr_en),
    .wr_addr (pl_wr_addr),
    .wr_data (pl_wr_data),
    .rd_en   (1'b1),
    .rd_addr (pl_rd_addr),
    .rd_data (pl_rd_data)
  );

  // Opcodes and tags.
  slm_ram #(.DEPTH(POOL_SLOTS), .WIDTH(2 * WW)) u_step_ram (
    .clk     (clk),
    .wr_en   (dm_wr_en),
    .wr_addr (dm_wr_addr),
    .wr_data (dm_wr_data),
    .rd_en   (dm_rd_en),
    .rd_addr (dm_rd_addr),
    .rd_data (dm_rd_data)
  );

  // Slot allocation.
  slm_free_map #(.POOL_SLOTS(POOL_SLOTS)) u_free (
    .clk          (clk),
    .rst_n        (rst_n),
    .alloc_en     (alloc_en),
    .release_en   (release_en),
    .release_slot (release_slot),
    .found        (free_found),
    .low_slot     (free_low)
  );

  // Result packing.
  assign out_tdata = {4'b0, done_count, pending_count, head_tag, head_code, status};

endmodule

// ----- design/slm_ram.sv -----
module slm_ram #(
  parameter int unsigned DEPTH = slm_pkg::POOL_SLOTS_DEF,
  parameter int unsigned WIDTH = 4,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // One read port with registered data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/slm_free_map.sv -----
module slm_free_map #(
  parameter int unsigned POOL_SLOTS = slm_pkg::POOL_SLOTS_DEF,
  localparam int unsigned SW        = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          alloc_en,
  input  logic          release_en,
  input  logic [SW-1:0] release_slot,
  output logic          found,
  output logic [SW-1:0] low_slot
);

  logic [POOL_SLOTS-1:0] free_r;

  // Lowest free slot: scan from the top so the lowest hit wins.
  always_comb begin
    found    = 1'b0;
    low_slot = '0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        found    = 1'b1;
        low_slot = SW'(i);
      end
    end
  end

  // All slots are free after reset; allocation and release never coincide.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '1;
    end else begin
      if (alloc_en) begin
        free_r[low_slot] <= 1'b0;
      end
      if (release_en) begin
        free_r[release_slot] <= 1'b1;
      end
    end
  end

endmodule

// ----- design/slm_seq.sv -----
module slm_seq #(
  parameter int unsigned POOL_SLOTS = slm_pkg::POOL_SLOTS_DEF,
  localparam int unsigned SW        = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1,
  localparam int unsigned CW        = $clog2(POOL_SLOTS + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Request side
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [slm_pkg::REQ_W-1:0]      in_req,
  input  logic [slm_pkg::WORD_W-1:0]     in_code,
  input  logic [slm_pkg::WORD_W-1:0]     in_tag,
  // Result side
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [slm_pkg::STAT_W-1:0]     out_status,
  output logic [slm_pkg::WORD_W-1:0]     out_code,
  output logic [slm_pkg::WORD_W-1:0]     out_tag,
  output logic [slm_pkg::CNT_O_W-1:0]    out_pend,
  output logic [slm_pkg::CNT_O_W-1:0]    out_done,
  // Next-link memory
  output logic                           nl_wr_en,
  output logic [SW-1:0]                  nl_wr_addr,
  output logic [SW-1:0]                  nl_wr_data,
  output logic [SW-1:0]                  nl_rd_addr,
  input  logic [SW-1:0]                  nl_rd_data,
  // Prev-link memory
  output logic                           pl_wr_en,
  output logic [SW-1:0]                  pl_wr_addr,
  output logic [SW-1:0]                  pl_wr_data,
  output logic [SW-1:0]                  pl_rd_addr,
  input  logic [SW-1:0]                  pl_rd_data,
  // Step data memory: opcode in the upper word, tag in the lower word
  output logic                           dm_wr_en,
  output logic [SW-1:0]                  dm_wr_addr,
  output logic [2*slm_pkg::WORD_W-1:0]   dm_wr_data,
  output logic                           dm_rd_en,
  output logic [SW-1:0]                  dm_rd_addr,
  input  logic [2*slm_pkg::WORD_W-1:0]   dm_rd_data,
  // Free map
  output logic                           alloc_en,
  output logic                           release_en,
  output logic [SW-1:0]                  release_slot,
  input  logic                           free_found,
  input  logic [SW-1:0]                  free_low
);

  localparam int unsigned WW = slm_pkg::WORD_W;
  localparam int unsigned OW = slm_pkg::CNT_O_W;

  slm_pkg::state_t  state_r, state_nxt;
  slm_pkg::req_t    req_r;
  logic [WW-1:0]    code_r, tag_r;
  logic [SW-1:0]    first_r, first_nxt;
  logic [SW-1:0]    bound_r, bound_nxt;
  logic [SW-1:0]    last_r, last_nxt;
  logic [SW-1:0]    victim_r, victim_nxt;
  logic [CW-1:0]    pend_r, pend_nxt;
  logic [CW-1:0]    done_r, done_nxt;
  slm_pkg::status_t status_r, status_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_load;
  logic [OW+CW-1:0] pend_ext, done_ext;
  logic [SW-1:0]    dd_slot;
  logic             has_prev, has_next;

  // Newest done step: just ahead of the head pending step, else the tail.
  assign dd_slot = (pend_r != '0) ? pl_rd_data : last_r;

  assign in_ready = (state_r == slm_pkg::S_IDLE);
  assign out_load = (state_r == slm_pkg::S_OUT) && (!out_valid_r || out_ready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      slm_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = slm_pkg::S_LINK;
        end
      end
      slm_pkg::S_LINK: begin
        if ((req_r == slm_pkg::REQ_DROP_DONE) && (done_r != '0)) begin
          state_nxt = slm_pkg::S_UNLINK;
        end else begin
          state_nxt = slm_pkg::S_HEAD;
        end
      end
      slm_pkg::S_UNLINK: state_nxt = slm_pkg::S_HEAD;
      slm_pkg::S_HEAD:   state_nxt = slm_pkg::S_OUT;
      slm_pkg::S_OUT: begin
        if (out_load) begin
          state_nxt = slm_pkg::S_IDLE;
        end
      end
      default: state_nxt = slm_pkg::S_IDLE;
    endcase
  end

  // List update, memory accesses and free map commands.
  always_comb begin
    first_nxt    = first_r;
    bound_nxt    = bound_r;
    last_nxt     = last_r;
    victim_nxt   = victim_r;
    pend_nxt     = pend_r;
    done_nxt     = done_r;
    status_nxt   = status_r;
    nl_wr_en     = 1'b0;
    nl_wr_addr   = '0;
    nl_wr_data   = '0;
    pl_wr_en     = 1'b0;
    pl_wr_addr   = '0;
    pl_wr_data   = '0;
    dm_wr_en     = 1'b0;
    dm_wr_addr   = free_low;
    dm_wr_data   = {code_r, tag_r};
    dm_rd_en     = 1'b0;
    dm_rd_addr   = bound_r;
    alloc_en     = 1'b0;
    release_en   = 1'b0;
    release_slot = bound_r;
    nl_rd_addr   = bound_r;
    pl_rd_addr   = bound_r;
    has_prev     = 1'b0;
    has_next     = 1'b0;
    unique case (state_r)
      slm_pkg::S_LINK: begin
        // Link data of the head pending step is on the read ports here.
        status_nxt = slm_pkg::ST_OK;
        nl_rd_addr = dd_slot;
        pl_rd_addr = dd_slot;
        case (req_r)
          slm_pkg::REQ_APPEND: begin
            if (code_r == '0) begin
              status_nxt = slm_pkg::ST_BADCODE;
            end else if (!free_found) begin
              status_nxt = slm_pkg::ST_FULL;
            end else begin
              alloc_en = 1'b1;
              dm_wr_en = 1'b1;
              if ((pend_r == '0) && (done_r == '0)) begin
                first_nxt = free_low;
              end else begin
                nl_wr_en   = 1'b1;
                nl_wr_addr = last_r;
                nl_wr_data = free_low;
                pl_wr_en   = 1'b1;
                pl_wr_addr = free_low;
                pl_wr_data = last_r;
              end
              last_nxt = free_low;
              if (pend_r == '0) begin
                bound_nxt = free_low;
              end
              pend_nxt = pend_r + CW'(1);
            end
          end
          slm_pkg::REQ_COMPLETE: begin
            if (pend_r == '0) begin
              status_nxt = slm_pkg::ST_EMPTY;
            end else begin
              pend_nxt = pend_r - CW'(1);
              done_nxt = done_r + CW'(1);
              if (pend_r > CW'(1)) begin
                bound_nxt = nl_rd_data;
              end
            end
          end
          slm_pkg::REQ_DROP_PEND: begin
            if (pend_r == '0) begin
              status_nxt = slm_pkg::ST_EMPTY;
            end else begin
              has_prev = (done_r != '0);
              has_next = (pend_r > CW'(1));
              if (has_next) begin
                bound_nxt = nl_rd_data;
              end
              if (has_prev && has_next) begin
                nl_wr_en   = 1'b1;
                nl_wr_addr = pl_rd_data;
                nl_wr_data = nl_rd_data;
                pl_wr_en   = 1'b1;
                pl_wr_addr = nl_rd_data;
                pl_wr_data = pl_rd_data;
              end else if (has_prev) begin
                last_nxt = pl_rd_data;
              end else if (has_next) begin
                first_nxt = nl_rd_data;
              end
              release_en   = 1'b1;
              release_slot = bound_r;
              pend_nxt     = pend_r - CW'(1);
            end
          end
          slm_pkg::REQ_DROP_DONE: begin
            // Links of the victim are read now and used in the unlink step.
            if (done_r == '0) begin
              status_nxt = slm_pkg::ST_EMPTY;
            end else begin
              victim_nxt = dd_slot;
            end
          end
          slm_pkg::REQ_REWIND: begin
            if (done_r != '0) begin
              pend_nxt  = pend_r + done_r;
              done_nxt  = '0;
              bound_nxt = first_r;
            end
          end
          default: begin
            status_nxt = (pend_r == '0) ? slm_pkg::ST_EMPTY : slm_pkg::ST_OK;
          end
        endcase
      end
      slm_pkg::S_UNLINK: begin
        // Remove the newest done step using its own links.
        has_prev = (done_r > CW'(1));
        has_next = (pend_r != '0);
        if (has_prev && has_next) begin
          nl_wr_en   = 1'b1;
          nl_wr_addr = pl_rd_data;
          nl_wr_data = nl_rd_data;
          pl_wr_en   = 1'b1;
          pl_wr_addr = nl_rd_data;
          pl_wr_data = pl_rd_data;
        end else if (has_prev) begin
          last_nxt = pl_rd_data;
        end else if (has_next) begin
          first_nxt = nl_rd_data;
        end
        release_en   = 1'b1;
        release_slot = victim_r;
        done_nxt     = done_r - CW'(1);
      end
      slm_pkg::S_HEAD: begin
        dm_rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // The output register is freed by the receiver or refilled by a new result.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slm_pkg::S_IDLE;
      first_r     <= '0;
      bound_r     <= '0;
      last_r      <= '0;
      pend_r      <= '0;
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      bound_r     <= bound_nxt;
      last_r      <= last_nxt;
      pend_r      <= pend_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and result payload.
  assign pend_ext = {{OW{1'b0}}, pend_r};
  assign done_ext = {{OW{1'b0}}, done_r};

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r  <= slm_pkg::req_t'(in_req);
      code_r <= in_code;
      tag_r  <= in_tag;
    end
    victim_r <= victim_nxt;
    status_r <= status_nxt;
    if (out_load) begin
      out_status <= status_r;
      out_code   <= (pend_r != '0) ? dm_rd_data[2*WW-1:WW] : '0;
      out_tag    <= (pend_r != '0) ? dm_rd_data[WW-1:0] : '0;
      out_pend   <= pend_ext[OW-1:0];
      out_done   <= done_ext[OW-1:0];
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- design/slm_checker.sv -----
module slm_checker #(
  parameter int unsigned POOL_SLOTS = slm_pkg::POOL_SLOTS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);

  logic [5:0] count_sum;
  logic       sum_checked;

  assign count_sum   = {1'b0, out_tdata[70:66]} + {1'b0, out_tdata[75:71]};
  assign sum_checked = (POOL_SLOTS < 32);

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // With no pending step the head fields read zero.
  a_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[70:66] == 5'd0) |->
      (out_tdata[33:2] == '0) && (out_tdata[65:34] == '0))
    else $error("head fields nonzero with no pending step");

  // A full report means every slot is in use.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && sum_checked && (out_tdata[1:0] == slm_pkg::ST_FULL) |->
      (count_sum == 6'(POOL_SLOTS)))
    else $error("full status with free slots");

  // The list never holds more steps than the pool.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && sum_checked |-> (count_sum <= 6'(POOL_SLOTS)))
    else $error("step counts exceed pool size");

  // Reset drops any offered result.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

endmodule

bind step_list_manager_with_rewind slm_checker #(.POOL_SLOTS(POOL_SLOTS)) u_slm_checker (.*);
